// ===== rtl/bmsort_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsort_pkg
// Shared types for the bottom-up merge sorter: the command and status groups
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bmsort_pkg;

  // Width of one element
  localparam int unsigned DataW = 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store the input beat, or mark an overflow
    logic pass_init;   // run width 1, first run pair, source is store A
    logic seg_init;    // set up pointers for the current run pair
    logic merge_step;  // write one merged element to the other store
    logic seg_next;    // move on to the next run pair
    logic pass_next;   // double run width, swap stores
    logic emit_init;   // read pointer back to zero
    logic emit_load;   // load the output register from the store
    logic clear;       // drop count and overflow flag
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sort_done;   // run width covers the whole set
    logic seg_none;    // no run pair left in this pass
    logic seg_end;     // final element of the run pair being written
    logic emit_last;   // element being emitted is the final one
    logic out_free;    // output register can take a beat this cycle
  } status_t;

endpackage

// ===== rtl/bmsort_dp.sv =====
// ----------------------------------------------------------------------------
// bmsort_dp
// Datapath of the merge sorter: two element stores used in ping-pong, the
// run pointers, the element count, the overflow flag and the output register.
// ----------------------------------------------------------------------------
module bmsort_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bmsort_pkg::cmd_t            cmd_i,
  output bmsort_pkg::status_t         status_o,
  input  logic [bmsort_pkg::DataW-1:0] in_value_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [bmsort_pkg::DataW-1:0] m_data_o,
  output logic                        m_last_o,
  output logic                        m_user_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);  // count width
  localparam int unsigned PW = CW + 2;                 // pointer width, room for sums
  localparam int unsigned AW = $clog2(MAX_ITEMS);      // store address width
  localparam int unsigned DW = bmsort_pkg::DataW;

  // Stores
  logic [DW-1:0] mem_a [MAX_ITEMS];
  logic [DW-1:0] mem_b [MAX_ITEMS];

  logic [DW-1:0] rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;

  // Control registers
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          src_q, src_d;
  logic [PW-1:0] width_q, width_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [PW-1:0] md_q, md_d;
  logic [PW-1:0] hi_q, hi_d;
  logic [PW-1:0] a_q, a_d;
  logic [PW-1:0] b_q, b_d;
  logic [PW-1:0] w_q, w_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_data_q;
  logic          out_last_q;
  logic          out_user_q;

  logic [PW-1:0] n_ext;
  logic [PW-1:0] sum_md, sum_hi;
  logic          full;
  logic [DW-1:0] head_l, head_r;
  logic          take_right;
  logic [DW-1:0] merge_data;
  logic          we_a, we_b;
  logic [AW-1:0] wa_a;
  logic [DW-1:0] wd_a;

  assign n_ext  = PW'(count_q);
  assign sum_md = lo_q + width_q;
  assign sum_hi = lo_q + (width_q << 1);
  assign full   = (count_q >= CW'(MAX_ITEMS));

  // Heads of the left and right runs from the source store
  assign head_l = src_q ? rd_b0_q : rd_a0_q;
  assign head_r = src_q ? rd_b1_q : rd_a1_q;

  // Left run wins ties, which keeps the sort stable
  assign take_right = (a_q >= md_q) ||
                      ((b_q < hi_q) && ($signed(head_l) > $signed(head_r)));
  assign merge_data = take_right ? head_r : head_l;

  // Store write ports: loads always fill store A
  assign we_a = (cmd_i.load && !full) || (cmd_i.merge_step && src_q);
  assign we_b = cmd_i.merge_step && !src_q;
  assign wa_a = cmd_i.load ? count_q[AW-1:0] : w_q[AW-1:0];
  assign wd_a = cmd_i.load ? in_value_i : merge_data;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a0_q <= mem_a[a_q[AW-1:0]];
    rd_a1_q <= mem_a[b_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[w_q[AW-1:0]] <= merge_data;
    end
    rd_b0_q <= mem_b[a_q[AW-1:0]];
    rd_b1_q <= mem_b[b_q[AW-1:0]];
  end

  // Pointer and count updates
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    src_d       = src_q;
    width_d     = width_q;
    lo_d        = lo_q;
    md_d        = md_q;
    hi_d        = hi_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    out_valid_d = out_valid_q && !m_ready_i;

    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.pass_init) begin
      width_d = PW'(1);
      lo_d    = '0;
      src_d   = 1'b0;
    end
    if (cmd_i.seg_init) begin
      md_d = (sum_md < n_ext) ? sum_md : n_ext;
      hi_d = (sum_hi < n_ext) ? sum_hi : n_ext;
      a_d  = lo_q;
      b_d  = (sum_md < n_ext) ? sum_md : n_ext;
      w_d  = lo_q;
    end
    if (cmd_i.merge_step) begin
      w_d = w_q + PW'(1);
      if (take_right) begin
        b_d = b_q + PW'(1);
      end else begin
        a_d = a_q + PW'(1);
      end
    end
    if (cmd_i.seg_next) begin
      lo_d = sum_hi;
    end
    if (cmd_i.pass_next) begin
      width_d = width_q << 1;
      lo_d    = '0;
      src_d   = !src_q;
    end
    if (cmd_i.emit_init) begin
      a_d = '0;
    end
    if (cmd_i.emit_load) begin
      a_d         = a_q + PW'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      src_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      md_q        <= '0;
      hi_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      src_q       <= src_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      md_q        <= md_d;
      hi_q        <= hi_d;
      a_q         <= a_d;
      b_q         <= b_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_data_q <= head_l;
      out_last_q <= (a_q + PW'(1) == n_ext);
      out_user_q <= ovf_q;
    end
  end

  // Status back to the controller
  assign status_o.sort_done = (width_q >= n_ext);
  assign status_o.seg_none  = (lo_q >= n_ext);
  assign status_o.seg_end   = (w_q + PW'(1) == hi_q);
  assign status_o.emit_last = (a_q + PW'(1) == n_ext);
  assign status_o.out_free  = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_user_q;

endmodule

// ===== rtl/bmsort_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmsort_ctrl
// Controller of the merge sorter: loading, merge passes and emission,
// sequenced by a one-hot state machine.
// ----------------------------------------------------------------------------
module bmsort_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_last_i,
  output logic                s_ready_o,
  input  bmsort_pkg::status_t status_i,
  output bmsort_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,  // taking input beats
    ST_SEG  = 6'b000010,  // pick next run pair or pass
    ST_MRD  = 6'b000100,  // run heads being read
    ST_MWR  = 6'b001000,  // write one merged element
    ST_ERD  = 6'b010000,  // sorted element being read
    ST_EOUT = 6'b100000   // hand element to output register
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = (state_q == ST_LOAD);
    case (state_q)
      ST_LOAD: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          if (s_last_i) begin
            cmd_o.pass_init = 1'b1;
            state_d         = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (status_i.sort_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_ERD;
        end else if (status_i.seg_none) begin
          cmd_o.pass_next = 1'b1;
        end else begin
          cmd_o.seg_init = 1'b1;
          state_d        = ST_MRD;
        end
      end
      ST_MRD: begin
        state_d = ST_MWR;
      end
      ST_MWR: begin
        cmd_o.merge_step = 1'b1;
        if (status_i.seg_end) begin
          cmd_o.seg_next = 1'b1;
          state_d        = ST_SEG;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_ERD: begin
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bottom_up_merge_sorter.sv =====
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter
// Collects signed values until a beat marked last, sorts them stably in
// ascending order and streams them out with the final one marked.
// ----------------------------------------------------------------------------
// Loading accepts one input beat per cycle. On the beat marked last the block
// stops taking input and sorts n held values with ceil(log2 n) merge passes;
// each pass writes every element once and the shared merge unit handles each
// element as a registered store read, then a compare and write, with a setup
// step for every run pair and a change-over step at the end of every pass.
// Emission reads each element from the store through the registered read
// before handing it to the output register, and waits while that register
// still holds a beat. Beats beyond MAX_ITEMS are dropped and tuser is high
// on every result of that set. The output register lets input loading of
// the next set begin while the final result still waits to be taken.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_res
  output logic        m_axis_tlast,   // last_res
  output logic        m_axis_tuser    // [0] truncated
);

  bmsort_pkg::cmd_t    cmd;
  bmsort_pkg::status_t status;

  bmsort_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bmsort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_value_i (s_axis_tdata),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast),
    .m_user_o   (m_axis_tuser)
  );

  // Input is closed while a set is being sorted
  a_last_closes_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready
  ) else $error("input still open after last beat");

  // Output register is never overwritten while holding a beat
  a_emit_needs_room: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> status.out_free
  ) else $error("output register overwritten");

  // Loading never shares a cycle with merging or emission
  a_load_merge_excl: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && (cmd.merge_step || cmd.emit_load))
  ) else $error("load overlaps sort or emission");

endmodule
